[rtl/tpc_pkg.sv]
`default_nettype none
package tpc_pkg;

  localparam int MAX_VERTICES_DEF  = 128;
  localparam int MAX_TRIANGLES_DEF = 128;

  localparam int CFG_W  = 13;
  localparam int COORD_W = 16;
  localparam int IDX_W  = 7;
  localparam int PIX_W  = 12;

  // Operation codes.
  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_TRI    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNLOADED = 2'd2;

  // Register indexes.
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // Start and result of one division job.
  typedef struct packed {
    logic        start;
    logic [29:0] num_mag;
    logic        neg;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/tpc_divider.sv]
`default_nettype none
module tpc_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpc_pkg::div_req_t req,
  output tpc_pkg::div_rsp_t      rsp
);
  import tpc_pkg::*;

  // Restoring division, one quotient bit per cycle, with saturation to 16 bits.
  logic [29:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] den_r;
  logic        neg_r, busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [17:0] trial;
  logic [29:0] sh;
  logic signed [15:0] q_r;

  always_comb begin
    sh      = quo_r << 1;
    trial   = {rem_r[16:0], quo_r[29]} - {1'b0, den_r};
    rem_nxt = {rem_r[16:0], quo_r[29]};
    quo_nxt = sh;
    if (!trial[17]) begin
      rem_nxt = trial;
      quo_nxt = sh | 30'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        quo_r  <= req.num_mag;
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (neg_r) begin
            q_r <= (quo_nxt > 30'd32768) ? -16'sd32768 : -$signed(quo_nxt[15:0]);
          end else begin
            q_r <= (quo_nxt > 30'd32767) ? 16'sd32767 : $signed(quo_nxt[15:0]);
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule
`default_nettype wire

[rtl/triangle_pixel_coverage.sv]
`default_nettype none
// Vertex load: two passes of a shared 30-step divider, x then y, each with a start flag.
// Vertex with depth at or below zero, triangle load and clear: answered from idle. Pixel
// query: per triangle walked, one triangle store read, three vertex store reads on a
// single read port and one test state. One item at a time; a result waits in an output
// register and in_tready returns when it is taken. Synchronous active-low reset clears
// counts and control and sets width and height to 100, not the stores.
module triangle_pixel_coverage #(
  parameter int MAX_VERTICES  = tpc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = tpc_pkg::MAX_TRIANGLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[1:0], vertex_x[17:2], vertex_y[33:18], vertex_z[49:34], tri_first[56:50],
  // tri_second[63:57], tri_third[70:64], pixel_x[82:71], pixel_y[94:83], zeros
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // covered[0], status[2:1], zeros
  output logic [7:0]       out_tdata
);
  import tpc_pkg::*;

  localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int TA_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int VC_W = $clog2(MAX_VERTICES + 1);
  localparam int TC_W = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIVX  = 10'b0000000010,
    S_DIVY  = 10'b0000000100,
    S_TRD   = 10'b0000001000,
    S_VA    = 10'b0000010000,
    S_VB    = 10'b0000100000,
    S_VC    = 10'b0001000000,
    S_VW    = 10'b0010000000,
    S_TEST  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [CFG_W-1:0] w_r, h_r;
  logic [VC_W-1:0] vcnt_r;
  logic [TC_W-1:0] tcnt_r, tptr_r;
  logic signed [15:0] vx_r, vy_r, vz_r;
  logic [PIX_W-1:0] px_r, py_r;
  logic signed [15:0] cx_r;
  logic covered_r;
  logic [1:0] status_r;

  // Stores with registered reads.
  logic [32:0] vmem [MAX_VERTICES];
  logic [20:0] tmem [MAX_TRIANGLES];
  logic [32:0] vrd_r;
  logic [20:0] trd_r;
  logic [VA_W-1:0] vra;
  logic [TA_W-1:0] tra;
  logic vwe, twe;
  logic [32:0] vwd;

  always_ff @(posedge clk) begin
    if (vwe) vmem[vcnt_r[VA_W-1:0]] <= vwd;
    if (twe) tmem[tcnt_r[TA_W-1:0]] <= {in_tdata[70:64], in_tdata[63:57], in_tdata[56:50]};
    vrd_r <= vmem[vra];
    trd_r <= tmem[tra];
  end

  // Fetched triangle corners.
  logic signed [15:0] ax_r, ay_r, bx_r, by_r, qx_r, qy_r;
  logic vis_r;

  always_comb begin
    tra = tptr_r[TA_W-1:0];
    unique case (state_r)
      S_VA:    vra = VA_W'(trd_r[IDX_W-1:0]);
      S_VB:    vra = VA_W'(trd_r[2*IDX_W-1:IDX_W]);
      default: vra = VA_W'(trd_r[3*IDX_W-1:2*IDX_W]);
    endcase
  end

  // Divider shared by both projection axes.
  div_req_t dreq;
  div_rsp_t drsp;
  tpc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [16:0] nx, ny, axn;
  logic [16:0] nmag;
  logic [29:0] prod;
  logic [CFG_W-1:0] sz;
  always_comb begin
    nx   = 17'(vx_r) + 17'(vz_r);
    ny   = 17'(vz_r) - 17'(vy_r);
    axn  = (state_r == S_IDLE) ? nx : ny;
    nmag = axn[16] ? 17'(-axn) : 17'(axn);
    sz   = (state_r == S_IDLE) ? w_r : h_r;
    prod = 30'(nmag) * 30'(sz);
    dreq.num_mag = prod;
    dreq.neg     = axn[16] && (prod != '0);
    dreq.den     = {vz_r, 1'b0};
  end

  // Edge functions over the registered corners, all three evaluated in S_TEST.
  logic signed [17:0] px_s, py_s;
  logic signed [36:0] e0, e1, e2;
  logic inbox, neg, pos;
  always_comb begin
    px_s = 18'(px_r);
    py_s = 18'(py_r);
    e0 = 37'((18'(bx_r) - 18'(ax_r))) * 37'((py_s - 18'(ay_r)))
       - 37'((18'(by_r) - 18'(ay_r))) * 37'((px_s - 18'(ax_r)));
    e1 = 37'((18'(qx_r) - 18'(bx_r))) * 37'((py_s - 18'(by_r)))
       - 37'((18'(qy_r) - 18'(by_r))) * 37'((px_s - 18'(bx_r)));
    e2 = 37'((18'(ax_r) - 18'(qx_r))) * 37'((py_s - 18'(qy_r)))
       - 37'((18'(ay_r) - 18'(qy_r))) * 37'((px_s - 18'(qx_r)));
    inbox = !((px_s < 18'(ax_r)) && (px_s < 18'(bx_r)) && (px_s < 18'(qx_r)))
         && !((px_s > 18'(ax_r)) && (px_s > 18'(bx_r)) && (px_s > 18'(qx_r)))
         && !((py_s < 18'(ay_r)) && (py_s < 18'(by_r)) && (py_s < 18'(qy_r)))
         && !((py_s > 18'(ay_r)) && (py_s > 18'(by_r)) && (py_s > 18'(qy_r)));
    neg = e0[36] || e1[36] || e2[36];
    pos = (!e0[36] && e0 != '0) || (!e1[36] && e1 != '0) || (!e2[36] && e2 != '0);
  end

  // The x division starts from the idle cycle in which the vertex is registered, so
  // start is raised through a flag in the cycle after the vertex is accepted.
  logic start_r;
  always_comb dreq.start = start_r;

  logic go_x, vwe_z;
  assign in_tready  = (state_r == S_IDLE) && !out_tvalid && !start_r;
  assign go_x       = in_tvalid && in_tready && (in_tdata[1:0] == OP_VERTEX)
                      && (vcnt_r < VC_W'(MAX_VERTICES)) && (in_tdata[49] == 1'b0)
                      && (in_tdata[49:34] != 16'd0);
  // A vertex at or behind the camera plane is stored as all zeros, not visible.
  assign vwe_z      = in_tvalid && in_tready && (in_tdata[1:0] == OP_VERTEX)
                      && (vcnt_r < VC_W'(MAX_VERTICES)) && !go_x;
  assign vwd        = vwe_z ? 33'd0 : {1'b1, drsp.quo, cx_r};
  assign vwe        = ((state_r == S_DIVY) && drsp.done) || vwe_z;
  assign twe        = in_tvalid && in_tready && (in_tdata[1:0] == OP_TRI)
                      && (tcnt_r < TC_W'(MAX_TRIANGLES))
                      && (32'(in_tdata[56:50]) < 32'(vcnt_r))
                      && (32'(in_tdata[63:57]) < 32'(vcnt_r))
                      && (32'(in_tdata[70:64]) < 32'(vcnt_r));
  assign out_tdata  = {5'd0, status_r, covered_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      w_r        <= 13'd100;
      h_r        <= 13'd100;
      vcnt_r     <= '0;
      tcnt_r     <= '0;
      out_tvalid <= 1'b0;
      start_r    <= 1'b0;
    end else begin
      start_r <= go_x || ((state_r == S_DIVX) && drsp.done);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  w_r <= cfg_wdata;
          REG_HEIGHT: h_r <= cfg_wdata;
          default:    ;
        endcase
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start_r) begin
            state_r <= S_DIVX;
          end else if (in_tvalid && in_tready) begin
            vx_r      <= in_tdata[17:2];
            vy_r      <= in_tdata[33:18];
            vz_r      <= in_tdata[49:34];
            px_r      <= in_tdata[82:71];
            py_r      <= in_tdata[94:83];
            covered_r <= 1'b0;
            unique case (in_tdata[1:0])
              OP_VERTEX: begin
                if (vcnt_r >= VC_W'(MAX_VERTICES)) begin
                  status_r   <= ST_FULL;
                  out_tvalid <= 1'b1;
                end else if (go_x) begin
                  status_r <= ST_OK;
                end else begin
                  status_r   <= ST_OK;
                  vcnt_r     <= vcnt_r + 1'b1;
                  out_tvalid <= 1'b1;
                end
              end
              OP_TRI: begin
                if (tcnt_r >= TC_W'(MAX_TRIANGLES)) begin
                  status_r <= ST_FULL;
                end else if (!twe) begin
                  status_r <= ST_UNLOADED;
                end else begin
                  status_r <= ST_OK;
                  tcnt_r   <= tcnt_r + 1'b1;
                end
                out_tvalid <= 1'b1;
              end
              OP_QUERY: begin
                status_r <= ST_OK;
                tptr_r   <= '0;
                state_r  <= S_TRD;
              end
              default: begin
                status_r   <= ST_OK;
                vcnt_r     <= '0;
                tcnt_r     <= '0;
                out_tvalid <= 1'b1;
              end
            endcase
          end
        end
        S_DIVX: begin
          if (drsp.done) begin
            cx_r    <= drsp.quo;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (drsp.done) begin
            vcnt_r     <= vcnt_r + 1'b1;
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_TRD: begin
          if (tptr_r >= tcnt_r) begin
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_VA;
          end
        end
        S_VA: state_r <= S_VB;
        S_VB: begin
          ax_r <= vrd_r[15:0]; ay_r <= vrd_r[31:16]; vis_r <= vrd_r[32];
          state_r <= S_VC;
        end
        S_VC: begin
          bx_r <= vrd_r[15:0]; by_r <= vrd_r[31:16]; vis_r <= vis_r & vrd_r[32];
          state_r <= S_VW;
        end
        S_VW: begin
          qx_r <= vrd_r[15:0]; qy_r <= vrd_r[31:16]; vis_r <= vis_r & vrd_r[32];
          state_r <= S_TEST;
        end
        S_TEST: begin
          if (vis_r && inbox && !(neg && pos)) begin
            covered_r  <= 1'b1;
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            tptr_r  <= tptr_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/tb_triangle_pixel_coverage.sv]
`default_nettype none
module tb_triangle_pixel_coverage;
  import tpc_pkg::*;

  // One input transfer, field by field, at the widths of the block.
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [6:0]         ia;
    logic [6:0]         ib;
    logic [6:0]         ic;
    logic [11:0]        px;
    logic [11:0]        py;
  } item_t;

  typedef struct {
    logic covered;
    logic [1:0] status;
  } answer_t;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    bit                 vis;
  } canvas_pt_t;

  // Tracks the block's stores and settings, and keeps the answers that are still
  // owed, oldest first.
  class coverage_board;
    int unsigned width = 100;
    int unsigned height = 100;
    canvas_pt_t  pts[MAX_VERTICES_DEF];
    logic [6:0]  tris[MAX_TRIANGLES_DEF][3];
    int unsigned vcount = 0;
    int unsigned tcount = 0;
    answer_t     owed[$];
    int          errors = 0;

    function void set_reg(logic [0:0] idx, logic [12:0] val);
      if (idx == REG_WIDTH) width = 32'(val);
      else height = 32'(val);
    endfunction

    function logic signed [15:0] project(int unsigned size, longint num, longint z);
      longint q;
      q = (longint'(size) * num) / (2 * z);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                             longint qx, longint qy);
      return (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
    endfunction

    function bit pixel_hit(longint qx, longint qy);
      longint x[3], y[3], e[3];
      bit skip, neg, pos;
      for (int t = 0; t < tcount; t++) begin
        skip = 0;
        for (int k = 0; k < 3; k++) begin
          if (!pts[tris[t][k]].vis) skip = 1;
          x[k] = longint'(pts[tris[t][k]].cx);
          y[k] = longint'(pts[tris[t][k]].cy);
        end
        if (skip) continue;
        if (qx < x[0] && qx < x[1] && qx < x[2]) continue;
        if (qx > x[0] && qx > x[1] && qx > x[2]) continue;
        if (qy < y[0] && qy < y[1] && qy < y[2]) continue;
        if (qy > y[0] && qy > y[1] && qy > y[2]) continue;
        e[0] = edge_fn(x[0], y[0], x[1], y[1], qx, qy);
        e[1] = edge_fn(x[1], y[1], x[2], y[2], qx, qy);
        e[2] = edge_fn(x[2], y[2], x[0], y[0], qx, qy);
        neg = 0;
        pos = 0;
        for (int k = 0; k < 3; k++) begin
          if (e[k] < 0) neg = 1;
          if (e[k] > 0) pos = 1;
        end
        if (!(neg && pos)) return 1;
      end
      return 0;
    endfunction

    // Called for each accepted input transfer.
    function void note(item_t it);
      answer_t a;
      canvas_pt_t p;
      a.covered = 0;
      a.status = ST_OK;
      case (it.op)
        OP_VERTEX: begin
          if (vcount >= MAX_VERTICES_DEF) begin
            a.status = ST_FULL;
          end else begin
            p.vis = it.vz > 0;
            p.cx = 0;
            p.cy = 0;
            if (p.vis) begin
              p.cx = project(width, longint'(it.vx) + longint'(it.vz), it.vz);
              p.cy = project(height, longint'(it.vz) - longint'(it.vy), it.vz);
            end
            pts[vcount] = p;
            vcount++;
          end
        end
        OP_TRI: begin
          if (tcount >= MAX_TRIANGLES_DEF) begin
            a.status = ST_FULL;
          end else if (it.ia >= vcount || it.ib >= vcount || it.ic >= vcount) begin
            a.status = ST_UNLOADED;
          end else begin
            tris[tcount][0] = it.ia;
            tris[tcount][1] = it.ib;
            tris[tcount][2] = it.ic;
            tcount++;
          end
        end
        OP_QUERY: a.covered = pixel_hit(longint'(it.px), longint'(it.py));
        default: begin
          vcount = 0;
          tcount = 0;
        end
      endcase
      owed.push_back(a);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Called for each accepted result transfer.
    task check(logic covered, logic [1:0] status);
      answer_t a;
      if (owed.size() == 0) begin
        report("result with nothing outstanding");
      end else begin
        a = owed.pop_front();
        if (covered !== a.covered)
          report($sformatf("covered %b, want %b", covered, a.covered));
        if (status !== a.status)
          report($sformatf("status %0d, want %0d", status, a.status));
      end
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [7:0]  out_tdata;

  coverage_board sb = new();
  bit hold_req = 0;

  always #1 clk = ~clk;

  triangle_pixel_coverage u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Result side. Values sampled at the rising edge are the ones from before the
  // edge, since the block updates through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata[0], out_tdata[2:1]);
  end

  // The receiver stalls at random, in moods that change now and then, so that
  // some stretches have no stalls at all. On request it holds off for a long
  // stretch so that the result register fills and the input side backs up.
  initial begin
    int mood;
    mood = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) mood = $urandom_range(0, 2);
      if (hold_req) begin
        out_tready <= 0;
        repeat (2000) @(negedge clk);
        hold_req = 0;
      end else if (mood == 0) begin
        out_tready <= 1;
      end else if (mood == 1) begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 39) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  // Gap between input transfers: mostly none, some short, a few long.
  task idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    if (r < 95) repeat ($urandom_range(1, 4)) @(negedge clk);
    else repeat ($urandom_range(20, 90)) @(negedge clk);
  endtask

  // Offers one item and holds it until the block takes it. The valid stays high
  // into the next item unless a gap follows.
  task send(item_t it);
    in_tvalid <= 1;
    in_tdata <= {1'b0, it.py, it.px, it.ic, it.ib, it.ia, it.vz, it.vy, it.vx, it.op};
    do @(posedge clk); while (!in_tready);
    sb.note(it);
    @(negedge clk);
    if ($urandom_range(0, 99) < 40) begin
      in_tvalid <= 0;
      @(negedge clk);
      idle_gap();
    end
  endtask

  task drain();
    in_tvalid <= 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Registers change only with the block idle; every op yields a result, so an
  // empty queue of owed answers means the block is done.
  task write_reg(logic [0:0] idx, int val);
    drain();
    repeat (5) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 13'(val);
    sb.set_reg(idx, 13'(val));
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Every field gets random bits; send tasks then overwrite the ones that matter.
  function item_t noise(logic [1:0] op);
    item_t it;
    it.op = op;
    it.vx = 16'($urandom);
    it.vy = 16'($urandom);
    it.vz = 16'($urandom);
    it.ia = 7'($urandom);
    it.ib = 7'($urandom);
    it.ic = 7'($urandom);
    it.px = 12'($urandom);
    it.py = 12'($urandom);
    return it;
  endfunction

  task vertex(int x, int y, int z);
    item_t it;
    it = noise(OP_VERTEX);
    it.vx = 16'(x);
    it.vy = 16'(y);
    it.vz = 16'(z);
    send(it);
  endtask

  task triangle(int a, int b, int c);
    item_t it;
    it = noise(OP_TRI);
    it.ia = 7'(a);
    it.ib = 7'(b);
    it.ic = 7'(c);
    send(it);
  endtask

  task query(int x, int y);
    item_t it;
    it = noise(OP_QUERY);
    it.px = 12'(x);
    it.py = 12'(y);
    send(it);
  endtask

  // A random item that mostly makes sense: vertices inside the view cone, triangles
  // over loaded vertices and pixels on the canvas. The rest is plain noise.
  task random_item();
    item_t it;
    int r, z, span;
    r = $urandom_range(0, 99);
    span = sb.width > sb.height ? sb.width : sb.height;
    if (span > 4095) span = 4095;
    if (r < 2) begin
      it = noise(OP_CLEAR);
    end else if (r < 36) begin
      it = noise(OP_VERTEX);
      if ($urandom_range(0, 9) != 0) begin
        z = $urandom_range(1, 3000);
        it.vz = 16'(z);
        it.vx = 16'(int'($urandom_range(0, 2 * z)) - z);
        it.vy = 16'(int'($urandom_range(0, 2 * z)) - z);
      end
    end else if (r < 60) begin
      it = noise(OP_TRI);
      if (sb.vcount != 0 && $urandom_range(0, 9) != 0) begin
        it.ia = 7'($urandom_range(0, sb.vcount - 1));
        it.ib = 7'($urandom_range(0, sb.vcount - 1));
        it.ic = 7'($urandom_range(0, sb.vcount - 1));
      end
    end else begin
      it = noise(OP_QUERY);
      if ($urandom_range(0, 9) != 0) begin
        it.px = 12'($urandom_range(0, span));
        it.py = 12'($urandom_range(0, span));
      end
    end
    send(it);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part at the reset canvas of 100 by 100.
    vertex(0, 0, 256);                 // lands on (50, 50)
    vertex(256, 0, 256);               // (100, 50)
    vertex(0, 256, 256);               // (50, 0)
    vertex(5, 5, 0);                   // zero depth is not visible
    vertex(-32768, 32767, -32768);     // most negative depth
    vertex(32767, -32768, 1);          // saturates both axes
    vertex(-32768, 32767, 32767);
    triangle(0, 1, 2);
    triangle(0, 1, 127);               // index not loaded yet
    triangle(0, 3, 1);                 // has a hidden vertex
    query(60, 40);
    query(95, 5);                      // in the box, outside the triangle
    query(4095, 4095);
    query(0, 0);
    triangle(2, 1, 0);                 // other winding
    triangle(5, 5, 5);                 // degenerate
    query(75, 30);
    query(50, 50);
    query(4095, 0);
    begin
      item_t it;
      it = noise(OP_CLEAR);
      send(it);
    end
    query(60, 40);
    triangle(0, 0, 0);                 // nothing loaded after clear
    vertex(0, 0, 256);
    triangle(0, 0, 0);
    query(50, 50);

    // Fill both stores past capacity, then query against a full triangle list.
    write_reg(REG_WIDTH, 64);
    write_reg(REG_HEIGHT, 64);
    for (int i = 0; i < 130; i++) vertex(int'($urandom_range(0, 400)) - 200,
                                         int'($urandom_range(0, 400)) - 200, 200);
    for (int i = 0; i < 130; i++) triangle($urandom_range(0, 127), $urandom_range(0, 127),
                                           $urandom_range(0, 127));
    for (int i = 0; i < 6; i++) query($urandom_range(0, 64), $urandom_range(0, 64));
    // Long receiver hold-off while the sender keeps offering items.
    hold_req = 1;
    for (int i = 0; i < 6; i++) query($urandom_range(0, 64), $urandom_range(0, 64));
    drain();
    begin
      item_t it;
      it = noise(OP_CLEAR);
      send(it);
    end

    // Random phases over a range of canvas sizes, the extremes among them.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(REG_WIDTH, 4096); write_reg(REG_HEIGHT, 4096); end
        1: begin write_reg(REG_WIDTH, 1); write_reg(REG_HEIGHT, 1); end
        2: begin write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 0); end
        3: begin write_reg(REG_WIDTH, 4096); write_reg(REG_HEIGHT, 1); end
        4: begin write_reg(REG_WIDTH, 8191); write_reg(REG_HEIGHT, 8191); end
        default: begin
          write_reg(REG_WIDTH, $urandom_range(1, 4096));
          write_reg(REG_HEIGHT, $urandom_range(1, 4096));
        end
      endcase
      for (int i = 0; i < 30; i++) random_item();
      // Sender pause until every owed answer has come back.
      if (ph == 3) drain();
    end

    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[triangle_pixel_coverage] OK");
    end else begin
      $display("[triangle_pixel_coverage] ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #6000000;
    $display("[triangle_pixel_coverage] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
